// File: rtl/oets_pkg.sv
// Package: shared constants and types of the odd-even transposition sorter.
`timescale 1ns / 1ps
`default_nettype none

package oets_pkg;

  // Fixed width of the channel value fields
  localparam int unsigned VALUE_W = 32;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_MAX_ELEMENTS = 32;
  localparam int unsigned DEF_DATA_WIDTH   = 32;

  // Per-cycle operation applied to the whole cell chain
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SHIFT_UP,    // cell i takes cell i-1, cell 0 takes the input value
    OP_SORT,        // one compare-exchange phase
    OP_SHIFT_DOWN   // cell i takes cell i+1, cell 0 is presented at the output
  } oets_op_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } oets_state_e;

  // Control handed to each cell
  typedef struct packed {
    oets_op_e op;
    logic     take_min;  // lower cell of an active pair
    logic     take_max;  // upper cell of an active pair
  } oets_cell_ctrl_t;

endpackage : oets_pkg

`default_nettype wire

// File: rtl/oets_in_if.sv
// Interface: input channel carrying one element per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface oets_in_if
  import oets_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      is_final;

  modport source (output valid, output value, output is_final, input ready);
  modport sink   (input valid, input value, input is_final, output ready);
endinterface : oets_in_if

`default_nettype wire

// File: rtl/oets_out_if.sv
// Interface: output channel carrying one sorted element per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface oets_out_if
  import oets_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] sorted_value;
  logic                      end_of_run;
  logic                      overflowed;

  modport source (output valid, output sorted_value, output end_of_run,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input end_of_run,
                  input overflowed, output ready);
endinterface : oets_out_if

`default_nettype wire

// File: rtl/oets_cell.sv
// Module: one storage cell of the sorting chain with its compare-exchange logic.
`timescale 1ns / 1ps
`default_nettype none

module oets_cell
  import oets_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  wire logic                         clk_i,
  input  wire oets_cell_ctrl_t              ctrl_i,
  input  wire logic signed [DATA_WIDTH-1:0] left_val_i,
  input  wire logic                         left_gt_i,
  input  wire logic signed [DATA_WIDTH-1:0] right_val_i,
  output logic signed [DATA_WIDTH-1:0]      val_o,
  output logic                              gt_o
);

  logic signed [DATA_WIDTH-1:0] val_q, val_d;

  // this cell greater than its upper neighbor
  assign gt_o  = (val_q > right_val_i);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    case (ctrl_i.op)
      OP_SHIFT_UP:   val_d = left_val_i;
      OP_SHIFT_DOWN: val_d = right_val_i;
      OP_SORT: begin
        if (ctrl_i.take_min && gt_o) begin
          val_d = right_val_i;
        end else if (ctrl_i.take_max && left_gt_i) begin
          val_d = left_val_i;
        end
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule : oets_cell

`default_nettype wire

// File: rtl/odd_even_transposition_sorter_top.sv
// Top level: odd-even transposition sorter built as a chain of cells.
//
// Usage:
//   in_i  (sink)   one element per transaction; is_final marks the last element
//                  of a set and starts sorting.
//   out_o (source) the set in ascending order, one element per transaction;
//                  end_of_run on the last one, overflowed on all of them when
//                  elements beyond MAX_ELEMENTS were dropped from the set.
// Timing for a set of n held elements (1 <= n <= MAX_ELEMENTS):
//   load : one element per cycle while in_i.valid, shifted into cell 0.
//   sort : phases 0 to n-1, each one odd-even phase across all cells.
//   emit : one element per cycle while out_o.ready, shifted out of cell 0.
//   First result is valid after the last sort phase, and the time for a set
//   is set by the serial load/emit shift and the phase counter.
// in_i.ready is high only while loading; the block handles one set at a time.
// A stalled receiver simply holds the chain: out_o holds valid and payload
// until the transaction completes.
// Reset clears the sequencer, element count and drop flag; cell contents are
// not reset and are only read after being loaded.
`timescale 1ns / 1ps
`default_nettype none

module odd_even_transposition_sorter_top
  import oets_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  parameter int unsigned DATA_WIDTH   = DEF_DATA_WIDTH
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  oets_in_if.sink     in_i,
  oets_out_if.source  out_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CNT_W-1:0] CntFull = CNT_W'(MAX_ELEMENTS);
  localparam logic [CNT_W-1:0] CntOne  = CNT_W'(1);

  // sequencer state
  oets_state_e      state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;   // held elements, then elements left to emit
  logic [CNT_W-1:0] phase_q, phase_d;   // sort phase index
  logic             drop_q, drop_d;
  oets_op_e         op;

  logic in_fire, out_fire;

  // chain signals
  logic signed [DATA_WIDTH-1:0] cell_val [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0]      cell_gt;
  logic signed [DATA_WIDTH-1:0] in_val;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  // keep the low DATA_WIDTH bits, sign-extend when wider
  assign in_val = DATA_WIDTH'(in_i.value);

  // Next state and chain operation
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    phase_d    = phase_q;
    drop_d     = drop_q;
    op         = OP_HOLD;
    in_i.ready = 1'b0;
    out_o.valid = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (count_q != CntFull) begin
            op      = OP_SHIFT_UP;
            count_d = count_q + CntOne;
          end else begin
            drop_d = 1'b1;
          end
          if (in_i.is_final) begin
            state_d = ST_SORT;
            phase_d = '0;
          end
        end
      end
      ST_SORT: begin
        op      = OP_SORT;
        phase_d = phase_q + CntOne;
        if (phase_q == count_q - CntOne) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_o.valid = 1'b1;
        if (out_o.ready) begin
          op      = OP_SHIFT_DOWN;
          count_d = count_q - CntOne;
          if (count_q == CntOne) begin
            state_d = ST_LOAD;
            drop_d  = 1'b0;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      phase_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      phase_q <= phase_d;
      drop_q  <= drop_d;
    end
  end

  // Cell chain; pair (i, i+1) is active when i matches the phase parity
  // and i+1 lies inside the held set.
  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    localparam logic             IsOdd = 1'(i % 2);
    localparam logic [CNT_W-1:0] NextIdx = CNT_W'(i + 1);
    localparam logic [CNT_W-1:0] ThisIdx = CNT_W'(i);

    oets_cell_ctrl_t              ctrl;
    logic signed [DATA_WIDTH-1:0] left_val;
    logic signed [DATA_WIDTH-1:0] right_val;
    logic                         left_gt;

    assign ctrl.op       = op;
    assign ctrl.take_min = (IsOdd == phase_q[0]) && (NextIdx < count_q);

    if (i == 0) begin : g_first
      assign left_val      = in_val;
      assign left_gt       = 1'b0;
      assign ctrl.take_max = 1'b0;
    end else begin : g_inner
      assign left_val      = cell_val[i-1];
      assign left_gt       = cell_gt[i-1];
      assign ctrl.take_max = (IsOdd != phase_q[0]) && (ThisIdx < count_q);
    end

    if (i == MAX_ELEMENTS - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_mid
      assign right_val = cell_val[i+1];
    end

    oets_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .left_val_i  (left_val),
      .left_gt_i   (left_gt),
      .right_val_i (right_val),
      .val_o       (cell_val[i]),
      .gt_o        (cell_gt[i])
    );
  end

  // Output straight from the registered head cell
  assign out_o.sorted_value = VALUE_W'(cell_val[0]);
  assign out_o.end_of_run   = (count_q == CntOne);
  assign out_o.overflowed   = drop_q;

  // Assertions
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input accepted while emitting");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("element count beyond capacity");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SORT) |-> (phase_q < count_q))
    else $error("sort phase beyond held count");

  a_final_sorts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.is_final) |=> (state_q == ST_SORT && count_q != '0))
    else $error("final element did not start sorting");

  a_run_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_o.end_of_run) |=> (count_q == '0 && !drop_q && state_q == ST_LOAD))
    else $error("set state not cleared after last result");

endmodule : odd_even_transposition_sorter_top

`default_nettype wire

// File: tb/sv/testbench.sv
// Testbench: odd-even transposition sorter, random sets checked against an in-bench predictor.
`timescale 1ns / 1ps

// Sets of signed elements go in through the element channel, each set closed by
// an element flagged is_final. A predictor holds its own copy of the element
// store, count and drop flag. On every final element it runs the same
// alternating even/odd compare-exchange phases and queues the sorted set.
// Every result transaction is checked field by field against the oldest
// queued element.
// The sender works in bursts with random gaps. The receiver cycles through
// several ready patterns. Coverage includes single-element sets, extreme and
// equal values, exactly full sets, and sets whose final element is dropped.
module testbench;
  import oets_pkg::*;

  localparam int unsigned MAX_ELEMENTS = DEF_MAX_ELEMENTS;
  localparam int unsigned DATA_W       = DEF_DATA_WIDTH;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned MAX_REPORTS  = 10;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  // One element transaction waiting to be driven
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      is_final;
  } set_elem_t;

  // One sorted element as it should leave the block
  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      end_of_run;
    logic                      overflowed;
  } sorted_elem_t;

  // Receiver ready patterns
  typedef enum logic [1:0] {
    RX_STEADY,      // always ready, no idling
    RX_TOGGLE,      // ready alternates high and low
    RX_SPARSE,      // random one-in-three stall
    RX_LONG_STALL   // alternating ready and stall runs of random length
  } rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  oets_in_if  in_if ();
  oets_out_if out_if ();

  odd_even_transposition_sorter_top #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .DATA_WIDTH   (DATA_W)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Stimulus and expectation stores
  set_elem_t    elem_pending[$];
  sorted_elem_t sorted_expect[$];

  // Predictor state: its own copy of the element store, count and drop flag
  logic [DATA_W-1:0] held[MAX_ELEMENTS];
  int unsigned       held_count;
  logic              drop_seen;

  // Run statistics
  int unsigned sets_done;
  int unsigned overflow_sets;
  int unsigned full_sets;
  int unsigned results_checked;
  int unsigned mismatches;

  // Sender burst control
  int unsigned burst_left;
  int unsigned gap_left;

  // Receiver pattern control
  rx_mode_e    rx_mode;
  int unsigned rx_mode_left;
  int unsigned rx_run_left;

  // ---------------------------------------------------------------------------
  // Predictor: absorb one accepted element. A final element sorts the held
  // values with n alternating transposition phases and queues the results.
  // ---------------------------------------------------------------------------
  task automatic take_element(input logic signed [VALUE_W-1:0] v, input logic fin);
    sorted_elem_t             res;
    logic [DATA_W-1:0]        swap_tmp;
    logic signed [DATA_W-1:0] held_s;
    int unsigned              n;
    if (held_count < MAX_ELEMENTS) begin
      held[held_count] = DATA_W'(v);
      held_count++;
    end else begin
      // store full: element dropped, whole set gets flagged
      drop_seen = 1'b1;
    end
    if (fin) begin
      n = held_count;
      // phase p pairs up (j, j+1) starting at the even or odd index
      for (int unsigned p = 0; p < n; p++) begin
        for (int unsigned j = p % 2; j + 1 < n; j += 2) begin
          if ($signed(held[j]) > $signed(held[j+1])) begin
            swap_tmp  = held[j];
            held[j]   = held[j+1];
            held[j+1] = swap_tmp;
          end
        end
      end
      for (int unsigned k = 0; k < n; k++) begin
        held_s           = held[k];
        res.sorted_value = VALUE_W'(held_s);
        res.end_of_run   = (k + 1 == n);
        res.overflowed   = drop_seen;
        sorted_expect.push_back(res);
      end
      sets_done++;
      if (drop_seen) overflow_sets++;
      if (n == MAX_ELEMENTS) full_sets++;
      held_count = 0;
      drop_seen  = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_elem(input logic signed [VALUE_W-1:0] v, input logic fin);
    set_elem_t e;
    e.value    = v;
    e.is_final = fin;
    elem_pending.push_back(e);
  endtask

  // Mix of full-range values, extremes, near-extremes and a narrow band that
  // makes duplicates common.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          3: return '1;
          default: return VALUE_W'(1);
        endcase
      end
      1, 2: return VALUE_W'($urandom_range(0, 16)) - VALUE_W'(8);
      3: begin
        if ($urandom_range(0, 1) != 0) return VAL_MAX - VALUE_W'($urandom_range(0, 3));
        else return VAL_MIN + VALUE_W'($urandom_range(0, 3));
      end
      default: return $urandom();
    endcase
  endfunction

  // Random set length: mostly short, some large, a few exactly full or past
  // capacity (including a set whose final element is the one dropped).
  function automatic int unsigned pick_set_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(1, 6);
    else if (r < 16) return $urandom_range(7, MAX_ELEMENTS - 1);
    else if (r == 16) return MAX_ELEMENTS;
    else if (r == 17) return MAX_ELEMENTS + 1;
    else return $urandom_range(MAX_ELEMENTS + 2, MAX_ELEMENTS + 8);
  endfunction

  task automatic queue_random_sets(input int unsigned item_goal);
    int unsigned queued;
    int unsigned len;
    queued = 0;
    while (queued < item_goal) begin
      len = pick_set_len();
      for (int unsigned i = 0; i < len; i++) push_elem(pick_value(), i + 1 == len);
      queued += len;
    end
  endtask

  // Wait until every queued element went in and every sorted
  // element came back.
  task automatic wait_drained();
    while (elem_pending.size() != 0 || in_if.valid || sorted_expect.size() != 0)
      @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents elements from the pending queue in bursts of random
  // length separated by random gaps (a gap of zero gives unbroken streams).
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : elem_driver
    set_elem_t nxt;
    if (!rst_ni) begin
      in_if.valid    <= 1'b0;
      in_if.value    <= '0;
      in_if.is_final <= 1'b0;
      burst_left     <= 1;
      gap_left       <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left != 0 || elem_pending.size() == 0) begin
        in_if.valid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        nxt = elem_pending.pop_front();
        in_if.valid    <= 1'b1;
        in_if.value    <= nxt.value;
        in_if.is_final <= nxt.is_final;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 20);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
      end
    end
  end

  // Input monitor: every accepted element transaction feeds the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) take_element(in_if.value, in_if.is_final);
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready follows one of several patterns, switched at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_mode      <= RX_STEADY;
      rx_mode_left <= 30;
      rx_run_left  <= 0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_e'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(20, 120);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_STEADY: out_if.ready <= 1'b1;
        RX_TOGGLE: out_if.ready <= ~out_if.ready;
        RX_SPARSE: out_if.ready <= ($urandom_range(0, 2) != 0);
        RX_LONG_STALL: begin
          if (rx_run_left == 0) begin
            out_if.ready <= ~out_if.ready;
            rx_run_left  <= $urandom_range(1, 12);
          end else begin
            rx_run_left <= rx_run_left - 1;
          end
        end
        default: out_if.ready <= 1'b1;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each sorted transaction against the oldest
  // expectation, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    sorted_elem_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_checked++;
      if (sorted_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing expected: value %0d end %b ovf %b", $time,
                   out_if.sorted_value, out_if.end_of_run, out_if.overflowed);
      end else begin
        want = sorted_expect.pop_front();
        if (out_if.sorted_value !== want.sorted_value ||
            out_if.end_of_run   !== want.end_of_run ||
            out_if.overflowed   !== want.overflowed) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: exp value %0d end %b ovf %b, got value %0d end %b ovf %b",
                     $time, want.sorted_value, want.end_of_run, want.overflowed,
                     out_if.sorted_value, out_if.end_of_run, out_if.overflowed);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed sets, a drained pause, random sets in two halves
  // with another drained pause between them, then the final drain.
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.value     = '0;
    in_if.is_final  = 1'b0;
    out_if.ready    = 1'b0;
    held_count      = 0;
    drop_seen       = 1'b0;
    sets_done       = 0;
    overflow_sets   = 0;
    full_sets       = 0;
    results_checked = 0;
    mismatches      = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single-element sets at both extremes
    push_elem(VAL_MAX, 1'b1);
    push_elem(VAL_MIN, 1'b1);
    // extremes, signs and a duplicated pair in one set
    push_elem('0, 1'b0);
    push_elem('1, 1'b0);
    push_elem(VALUE_W'(1), 1'b0);
    push_elem(VAL_MIN, 1'b0);
    push_elem(VAL_MAX, 1'b0);
    push_elem(VALUE_W'(5), 1'b0);
    push_elem(VALUE_W'(5), 1'b0);
    push_elem(-VALUE_W'(5), 1'b1);
    // strictly descending: every phase has exchanges to do
    for (int i = 0; i < 8; i++) push_elem(VALUE_W'(1000 - 300 * i), i == 7);
    // all equal: nothing may move
    for (int i = 0; i < 3; i++) push_elem(-VALUE_W'(3), i == 2);

    wait_drained();
    queue_random_sets(RANDOM_ITEMS / 2);
    wait_drained();
    queue_random_sets(RANDOM_ITEMS / 2);
    wait_drained();

    // stray results would show up within a full set's emit time
    repeat (4 * MAX_ELEMENTS) @(posedge clk_i);

    $display("covered %0d sets: %0d exactly full, %0d with dropped elements",
             sets_done, full_sets, overflow_sets);
    $display("checked %0d sorted elements, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("timeout with %0d sorted elements still expected", sorted_expect.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule : testbench

// File: odd_even_transposition_sorter_top.f
rtl/oets_pkg.sv
rtl/oets_in_if.sv
rtl/oets_out_if.sv
rtl/oets_cell.sv
rtl/odd_even_transposition_sorter_top.sv
tb/sv/testbench.sv
